// File: rtl/phc_pkg.sv
// ----------------------------------------------------------------------------
// phc_pkg
// Shared widths, register indexes, types and helpers for the pinhole camera
// primary ray direction pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package phc_pkg;

    // configuration and field widths
    localparam int RES_BITS   = 12;
    localparam int CFG_RES_W  = RES_BITS + 1;
    localparam int COMP_BITS  = 16;
    localparam int VEC_W      = 3 * COMP_BITS;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = VEC_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_XRES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_YRES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_U_AXIS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_V_AXIS = 3'd4;

    localparam logic [CFG_RES_W-1:0] RES_RESET = CFG_RES_W'(640);

    // datapath widths
    localparam int T_W     = CFG_RES_W + 1;          // signed pixel term
    localparam int W_W     = 2 * T_W;                // signed weight
    localparam int PROD_W  = COMP_BITS + W_W;        // component times weight
    localparam int D_W     = PROD_W + 2;             // sum of three products
    localparam int MAG_W   = D_W;                    // magnitude of the sum
    localparam int NORM_W  = 30;                     // magnitude after scaling
    localparam int SH_MAX  = MAG_W - NORM_W;
    localparam int SH_W    = $clog2(SH_MAX + 1);
    localparam int SQ_W    = 2 * NORM_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int FRAC_W  = 15;
    localparam int NUM_W   = NORM_W + FRAC_W + 1;
    localparam int DEN_W   = ROOT_W + 1;
    localparam int Q_W     = 15;
    localparam logic [Q_W-1:0] OUT_ONE = Q_W'(16384);

    typedef logic [NORM_W-1:0] t_mag;

    // scaled magnitudes and signs of one direction
    typedef struct packed {
        logic [2:0]        neg;
        logic [2:0][NORM_W-1:0] mag;
    } t_norm;

    // one signed component of a packed vector
    function automatic logic signed [COMP_BITS-1:0] comp(
        input logic [VEC_W-1:0] vec,
        input int               idx
    );
        comp = vec[idx*COMP_BITS +: COMP_BITS];
    endfunction

endpackage

`default_nettype wire

// File: rtl/pinhole_camera_ray_direction.sv
// ----------------------------------------------------------------------------
// pinhole_camera_ray_direction
// Unit direction of the primary ray through a pixel centre of a pinhole camera.
// ----------------------------------------------------------------------------
// The block accepts one pixel beat per cycle unless the output stalls and
// returns one Q1.14 direction beat per pixel, in order. The pipeline holds
// the square root (one bit of the 31-bit root per stage) and the divider (one
// of 15 quotient bits per stage) behind six front stages and two for the
// squared length. The whole pipeline advances while the output register is
// empty or being taken, so back-pressure holds every stage in place. A zero
// resolution counts as one; write the registers only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pinhole_camera_ray_direction (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [phc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [phc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [phc_pkg::RES_BITS-1:0]        i_pixel_x,
    input  wire logic [phc_pkg::RES_BITS-1:0]        i_pixel_y,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [phc_pkg::OUT_W-1:0]         o_dir_x,
    output logic signed [phc_pkg::OUT_W-1:0]         o_dir_y,
    output logic signed [phc_pkg::OUT_W-1:0]         o_dir_z
);

    logic [phc_pkg::CFG_RES_W-1:0] r_xres, r_yres;
    logic [phc_pkg::VEC_W-1:0]     r_center, r_u_axis, r_v_axis;

    logic [phc_pkg::CFG_RES_W-1:0] xr, yr;
    logic                          en;
    logic                          front_valid, sqrt_valid;
    phc_pkg::t_norm                front_norm, sqrt_norm;
    logic [phc_pkg::ROOT_W-1:0]    sqrt_root;
    logic signed [phc_pkg::OUT_W-1:0] dir [0:2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xres   <= phc_pkg::RES_RESET;
            r_yres   <= phc_pkg::RES_RESET;
            r_center <= '0;
            r_u_axis <= '0;
            r_v_axis <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                phc_pkg::CFG_XRES:   r_xres   <= i_cfg_data[phc_pkg::CFG_RES_W-1:0];
                phc_pkg::CFG_YRES:   r_yres   <= i_cfg_data[phc_pkg::CFG_RES_W-1:0];
                phc_pkg::CFG_CENTER: r_center <= i_cfg_data;
                phc_pkg::CFG_U_AXIS: r_u_axis <= i_cfg_data;
                phc_pkg::CFG_V_AXIS: r_v_axis <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero resolution counts as one
    assign xr = (r_xres == '0) ? phc_pkg::CFG_RES_W'(1) : r_xres;
    assign yr = (r_yres == '0) ? phc_pkg::CFG_RES_W'(1) : r_yres;

    // global advance: output register empty or being taken
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    phc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_xr      (xr),
        .i_yr      (yr),
        .i_center  (r_center),
        .i_u_axis  (r_u_axis),
        .i_v_axis  (r_v_axis),
        .o_valid   (front_valid),
        .o_norm    (front_norm)
    );

    phc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_norm  (front_norm),
        .o_valid (sqrt_valid),
        .o_norm  (sqrt_norm),
        .o_root  (sqrt_root)
    );

    phc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sqrt_valid),
        .i_norm  (sqrt_norm),
        .i_root  (sqrt_root),
        .o_valid (o_valid),
        .o_dir   (dir)
    );

    assign o_dir_x = dir[0];
    assign o_dir_y = dir[1];
    assign o_dir_z = dir[2];

    // a stalled pipeline keeps its output beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_dir_x)
                                   && $stable(o_dir_y) && $stable(o_dir_z)))
        else $error("output beat changed under stall");

    // components stay within unit range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dir_x <= 16'sd16384 && o_dir_x >= -16'sd16384
                     && o_dir_y <= 16'sd16384 && o_dir_y >= -16'sd16384
                     && o_dir_z <= 16'sd16384 && o_dir_z >= -16'sd16384))
        else $error("direction component out of range");

    // ready follows the output register state
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

endmodule

`default_nettype wire

// File: rtl/phc_front.sv
// ----------------------------------------------------------------------------
// phc_front
// Pixel weights, weighted vector sum, sign-magnitude split and scaling of the
// offset into a thirty bit range. Six register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module phc_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_valid,
    input  wire logic [phc_pkg::RES_BITS-1:0]        i_pixel_x,
    input  wire logic [phc_pkg::RES_BITS-1:0]        i_pixel_y,
    input  wire logic [phc_pkg::CFG_RES_W-1:0]       i_xr,
    input  wire logic [phc_pkg::CFG_RES_W-1:0]       i_yr,
    input  wire logic [phc_pkg::VEC_W-1:0]           i_center,
    input  wire logic [phc_pkg::VEC_W-1:0]           i_u_axis,
    input  wire logic [phc_pkg::VEC_W-1:0]           i_v_axis,
    output logic                                     o_valid,
    output phc_pkg::t_norm                           o_norm
);

    logic [5:0] r_valid;

    logic signed [phc_pkg::T_W-1:0]    r_ta, r_tb;
    logic signed [phc_pkg::W_W-1:0]    r_wa, r_wb, r_wc;
    logic signed [phc_pkg::PROD_W-1:0] r_prod [0:2][0:2];
    logic [phc_pkg::MAG_W-1:0]         r_mag4 [0:2];
    logic [2:0]                        r_neg4;
    logic [phc_pkg::MAG_W-1:0]         r_mag5 [0:2];
    logic [2:0]                        r_neg5;
    logic [phc_pkg::SH_W-1:0]          r_sh;
    phc_pkg::t_norm                    r_norm;

    logic signed [phc_pkg::D_W-1:0]    n_sum [0:2];
    logic [phc_pkg::MAG_W-1:0]         n_or;
    logic [phc_pkg::SH_W-1:0]          n_sh;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[4:0], i_valid};
        end
    end

    // stage 1: signed pixel terms 2x+1-xres and yres-2y-1
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ta <= $signed({1'b0, i_pixel_x, 1'b1}) - $signed({1'b0, i_xr});
            r_tb <= $signed({1'b0, i_yr}) - $signed({1'b0, i_pixel_y, 1'b1});
        end
    end

    // stage 2: weights scaled by the other resolution, and the centre weight xres*yres
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wa <= r_ta * $signed({1'b0, i_yr});
            r_wb <= r_tb * $signed({1'b0, i_xr});
            r_wc <= $signed({1'b0, i_xr}) * $signed({1'b0, i_yr});
        end
    end

    // stage 3: nine component products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_prod[l][0] <= phc_pkg::comp(i_center, l) * r_wc;
                r_prod[l][1] <= phc_pkg::comp(i_u_axis, l) * r_wa;
                r_prod[l][2] <= phc_pkg::comp(i_v_axis, l) * r_wb;
            end
        end
    end

    // stage 4: sum per component, split into sign and magnitude
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_sum[l] = phc_pkg::D_W'(r_prod[l][0]) + phc_pkg::D_W'(r_prod[l][1])
                     + phc_pkg::D_W'(r_prod[l][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_neg4[l] <= n_sum[l][phc_pkg::D_W-1];
                r_mag4[l] <= n_sum[l][phc_pkg::D_W-1] ? phc_pkg::MAG_W'(-n_sum[l])
                                                       : phc_pkg::MAG_W'(n_sum[l]);
            end
        end
    end

    // stage 5: shift count from the leading one of the largest magnitude
    always_comb begin
        n_or = r_mag4[0] | r_mag4[1] | r_mag4[2];
        n_sh = '0;
        for (int k = phc_pkg::NORM_W; k < phc_pkg::MAG_W; k++) begin
            if (n_or[k]) begin
                n_sh = phc_pkg::SH_W'(k - phc_pkg::NORM_W + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag5 <= r_mag4;
            r_neg5 <= r_neg4;
            r_sh   <= n_sh;
        end
    end

    // stage 6: scale all three magnitudes by the common shift
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_norm.neg <= r_neg5;
            for (int l = 0; l < 3; l++) begin
                r_norm.mag[l] <= phc_pkg::NORM_W'(r_mag5[l] >> r_sh);
            end
        end
    end

    assign o_valid = r_valid[5];
    assign o_norm  = r_norm;

endmodule

`default_nettype wire

// File: rtl/phc_sqrt.sv
// ----------------------------------------------------------------------------
// phc_sqrt
// Squared length of the scaled offset and its integer square root, one root
// bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module phc_sqrt (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_valid,
    input  wire phc_pkg::t_norm                  i_norm,
    output logic                                 o_valid,
    output phc_pkg::t_norm                       o_norm,
    output logic [phc_pkg::ROOT_W-1:0]           o_root
);

    localparam int NST = phc_pkg::ROOT_W + 2;

    logic [NST-1:0]                  r_valid;
    logic [phc_pkg::SQ_W-1:0]        r_sq [0:2];
    phc_pkg::t_norm                  r_norm_sq;
    logic [phc_pkg::SUM_W-1:0]       r_rem  [0:phc_pkg::ROOT_W];
    logic [phc_pkg::ROOT_W-1:0]      r_root [0:phc_pkg::ROOT_W];
    phc_pkg::t_norm                  r_norm [0:phc_pkg::ROOT_W];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[NST-2:0], i_valid};
        end
    end

    // squares of the three magnitudes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_norm_sq <= i_norm;
            for (int l = 0; l < 3; l++) begin
                r_sq[l] <= i_norm.mag[l] * i_norm.mag[l];
            end
        end
    end

    // squared length
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= phc_pkg::SUM_W'(r_sq[0]) + phc_pkg::SUM_W'(r_sq[1])
                       + phc_pkg::SUM_W'(r_sq[2]);
            r_root[0] <= '0;
            r_norm[0] <= r_norm_sq;
        end
    end

    // one root bit per stage, most significant first
    for (genvar g = 0; g < phc_pkg::ROOT_W; g++) begin : g_root
        localparam int B = phc_pkg::ROOT_W - 1 - g;
        logic [phc_pkg::SUM_W-1:0] trial;

        assign trial = (phc_pkg::SUM_W'(r_root[g]) << (B + 1))
                     | (phc_pkg::SUM_W'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_norm[g+1] <= r_norm[g];
                if (r_rem[g] >= trial) begin
                    r_rem[g+1]  <= r_rem[g] - trial;
                    r_root[g+1] <= r_root[g] | (phc_pkg::ROOT_W'(1) << B);
                end else begin
                    r_rem[g+1]  <= r_rem[g];
                    r_root[g+1] <= r_root[g];
                end
            end
        end
    end

    assign o_valid = r_valid[NST-1];
    assign o_norm  = r_norm[phc_pkg::ROOT_W];
    assign o_root  = r_root[phc_pkg::ROOT_W];

endmodule

`default_nettype wire

// File: rtl/phc_div.sv
// ----------------------------------------------------------------------------
// phc_div
// Rounded division of each magnitude by the length, one quotient bit per
// register stage, then saturation and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module phc_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_valid,
    input  wire phc_pkg::t_norm                  i_norm,
    input  wire logic [phc_pkg::ROOT_W-1:0]      i_root,
    output logic                                 o_valid,
    output logic signed [phc_pkg::OUT_W-1:0]     o_dir [0:2]
);

    localparam int NST = phc_pkg::Q_W + 2;

    logic [NST-1:0]                 r_valid;
    logic [phc_pkg::NUM_W-1:0]      r_rem  [0:phc_pkg::Q_W][0:2];
    logic [phc_pkg::Q_W-1:0]        r_quo  [0:phc_pkg::Q_W][0:2];
    logic [phc_pkg::DEN_W-1:0]      r_den  [0:phc_pkg::Q_W];
    logic [2:0]                     r_neg  [0:phc_pkg::Q_W];
    logic                           r_zero [0:phc_pkg::Q_W];
    logic signed [phc_pkg::OUT_W-1:0] r_dir [0:2];

    logic [phc_pkg::Q_W-1:0]        n_mag [0:2];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[NST-2:0], i_valid};
        end
    end

    // numerators m*2^15 + r and denominator 2r
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= {i_root, 1'b0};
            r_neg[0]  <= i_norm.neg;
            r_zero[0] <= (i_root == '0);
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= {1'b0, i_norm.mag[l], {phc_pkg::FRAC_W{1'b0}}}
                             + phc_pkg::NUM_W'(i_root);
                r_quo[0][l] <= '0;
            end
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar g = 0; g < phc_pkg::Q_W; g++) begin : g_quo
        localparam int B = phc_pkg::Q_W - 1 - g;
        logic [phc_pkg::NUM_W-1:0] sub;

        assign sub = phc_pkg::NUM_W'(r_den[g]) << B;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[g+1]  <= r_den[g];
                r_neg[g+1]  <= r_neg[g];
                r_zero[g+1] <= r_zero[g];
                for (int l = 0; l < 3; l++) begin
                    if (r_rem[g][l] >= sub) begin
                        r_rem[g+1][l] <= r_rem[g][l] - sub;
                        r_quo[g+1][l] <= r_quo[g][l] | (phc_pkg::Q_W'(1) << B);
                    end else begin
                        r_rem[g+1][l] <= r_rem[g][l];
                        r_quo[g+1][l] <= r_quo[g][l];
                    end
                end
            end
        end
    end

    // saturate, force zero length to zero, apply sign
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (r_zero[phc_pkg::Q_W]) begin
                n_mag[l] = '0;
            end else if (r_quo[phc_pkg::Q_W][l] > phc_pkg::OUT_ONE) begin
                n_mag[l] = phc_pkg::OUT_ONE;
            end else begin
                n_mag[l] = r_quo[phc_pkg::Q_W][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_dir[l] <= r_neg[phc_pkg::Q_W][l]
                          ? -$signed(phc_pkg::OUT_W'(n_mag[l]))
                          :  $signed(phc_pkg::OUT_W'(n_mag[l]));
            end
        end
    end

    assign o_valid = r_valid[NST-1];
    assign o_dir   = r_dir;

endmodule

`default_nettype wire

// File: dv/pinhole_camera_ray_direction_tb.sv
// ----------------------------------------------------------------------------
// pinhole_camera_ray_direction_tb
// Streams pixel beats through the ray direction block under several camera
// set-ups and compares every direction beat with an in-bench predictor.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
} t_ray_dir;

class ray_scoreboard;
    logic [12:0] xres;
    logic [12:0] yres;
    logic [47:0] center;
    logic [47:0] u_axis;
    logic [47:0] v_axis;
    t_ray_dir    dir_q[$];
    int          errors;
    int          checked;

    function new();
        xres = 640;
        yres = 640;
        center = '0;
        u_axis = '0;
        v_axis = '0;
        errors = 0;
        checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [47:0] data);
        case (idx)
            phc_pkg::CFG_XRES:   xres = data[12:0];
            phc_pkg::CFG_YRES:   yres = data[12:0];
            phc_pkg::CFG_CENTER: center = data;
            phc_pkg::CFG_U_AXIS: u_axis = data;
            phc_pkg::CFG_V_AXIS: v_axis = data;
            default: ;
        endcase
    endfunction

    // bit-by-bit integer square root
    function longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // exact offset scaled by xres*yres, then normalised to q1.14
    function void note_pixel(logic [11:0] px, logic [11:0] py);
        longint          xr, yr, wa, wb, wc, d;
        longint unsigned mag[3];
        longint unsigned biggest, sum, r, q;
        logic [15:0]     res[3];
        bit              neg[3];
        t_ray_dir        dir;
        xr = (xres == 0) ? 1 : longint'(xres);
        yr = (yres == 0) ? 1 : longint'(yres);
        wa = (2 * longint'(px) + 1 - xr) * yr;
        wb = (yr - 2 * longint'(py) - 1) * xr;
        wc = xr * yr;
        biggest = 0;
        for (int i = 0; i < 3; i++) begin
            d = longint'($signed(center[i*16 +: 16])) * wc
              + longint'($signed(u_axis[i*16 +: 16])) * wa
              + longint'($signed(v_axis[i*16 +: 16])) * wb;
            neg[i] = d < 0;
            mag[i] = neg[i] ? longint'(-d) : longint'(d);
            if (mag[i] > biggest) biggest = mag[i];
        end
        while (biggest >= (64'd1 << 30)) begin
            biggest = biggest >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        r = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = 0;
            if (r != 0) begin
                q = ((mag[i] << 15) + r) / (2 * r);
                if (q > 16384) q = 16384;
            end
            if (neg[i]) q = -q;
            res[i] = q[15:0];
        end
        dir.x = res[0];
        dir.y = res[1];
        dir.z = res[2];
        dir_q = {dir_q, dir};
    endfunction

    function void check_dir(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z);
        t_ray_dir exp_dir;
        if (dir_q.size() == 0) begin
            $error("direction beat with nothing expected");
            errors++;
            return;
        end
        exp_dir = dir_q.pop_front();
        checked++;
        if (x !== exp_dir.x) begin
            $error("dir_x expected %0d actual %0d", exp_dir.x, x);
            errors++;
        end
        if (y !== exp_dir.y) begin
            $error("dir_y expected %0d actual %0d", exp_dir.y, y);
            errors++;
        end
        if (z !== exp_dir.z) begin
            $error("dir_z expected %0d actual %0d", exp_dir.z, z);
            errors++;
        end
    endfunction
endclass

module pinhole_camera_ray_direction_tb;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [phc_pkg::CFG_IDX_W-1:0]    i_cfg_idx;
    logic [phc_pkg::CFG_DATA_W-1:0]   i_cfg_data;
    logic                             i_valid;
    logic                             o_ready;
    logic [phc_pkg::RES_BITS-1:0]     i_pixel_x;
    logic [phc_pkg::RES_BITS-1:0]     i_pixel_y;
    logic                             o_valid;
    logic                             i_ready;
    logic signed [phc_pkg::OUT_W-1:0] o_dir_x;
    logic signed [phc_pkg::OUT_W-1:0] o_dir_y;
    logic signed [phc_pkg::OUT_W-1:0] o_dir_z;

    ray_scoreboard sb;
    bit            tx_idle_en;
    bit            rx_idle_en;
    bit            rx_hold_req;
    int            stall_cycles;
    int            pixels_sent;
    int            phases;

    pinhole_camera_ray_direction i_dut (.*);

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // beat monitor: note accepted pixels, check accepted directions
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_pixel(i_pixel_x, i_pixel_y);
            if (o_valid && i_ready) sb.check_dir(o_dir_x, o_dir_y, o_dir_z);
            if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (stall_cycles >= 5000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold on request
    initial begin
        i_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send_pixel(logic [11:0] px, logic [11:0] py);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        pixels_sent++;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // drop valid and wait for every outstanding direction, plus pipeline margin
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.dir_q.size() != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    // drive a register write, then drop the write enable so writes never collide
    task automatic write_reg(logic [2:0] idx, logic [47:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand_vec();
        logic [47:0] v;
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 7))
                0: v[i*16 +: 16] = 16'h7fff;
                1: v[i*16 +: 16] = 16'h8000;
                2: v[i*16 +: 16] = 16'h0000;
                default: v[i*16 +: 16] = 16'($urandom);
            endcase
        end
        return v;
    endfunction

    function automatic logic [12:0] rand_res();
        case ($urandom_range(0, 9))
            0: return 13'd1;
            1: return 13'd4096;
            2: return 13'd0;
            3: return 13'($urandom_range(1, 16));
            default: return 13'($urandom_range(1, 4096));
        endcase
    endfunction

    task automatic random_camera();
        drain();
        write_reg(phc_pkg::CFG_XRES, 48'(rand_res()));
        write_reg(phc_pkg::CFG_YRES, 48'(rand_res()));
        write_reg(phc_pkg::CFG_CENTER, rand_vec());
        write_reg(phc_pkg::CFG_U_AXIS, rand_vec());
        write_reg(phc_pkg::CFG_V_AXIS, rand_vec());
        phases++;
    endtask

    // mostly pixels inside the image, some anywhere in the field range
    task automatic random_pixels(int n);
        logic [11:0] px, py;
        int          xr, yr;
        for (int k = 0; k < n; k++) begin
            xr = (sb.xres == 0) ? 1 : (sb.xres > 4096 ? 4096 : sb.xres);
            yr = (sb.yres == 0) ? 1 : (sb.yres > 4096 ? 4096 : sb.yres);
            if ($urandom_range(0, 4) == 0) begin
                px = 12'($urandom);
                py = 12'($urandom);
            end else begin
                px = 12'($urandom_range(0, xr - 1));
                py = 12'($urandom_range(0, yr - 1));
            end
            send_pixel(px, py);
        end
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_pixel_x = '0;
        i_pixel_y = '0;
        stall_cycles = 0;
        pixels_sent = 0;
        phases = 0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        rx_hold_req = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero offset after reset gives an all-zero direction
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hfff, 12'hfff);

        // zero resolution counts as one, extreme vectors
        drain();
        write_reg(phc_pkg::CFG_XRES, 48'd0);
        write_reg(phc_pkg::CFG_YRES, 48'd0);
        write_reg(phc_pkg::CFG_CENTER, {16'h7fff, 16'h8000, 16'h7fff});
        write_reg(phc_pkg::CFG_U_AXIS, {16'h8000, 16'h7fff, 16'h8000});
        write_reg(phc_pkg::CFG_V_AXIS, {16'h7fff, 16'h7fff, 16'h8000});
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hfff, 12'd0);
        send_pixel(12'd0, 12'hfff);
        send_pixel(12'hfff, 12'hfff);

        // full resolution, pixels at the corners and inside the image
        drain();
        write_reg(phc_pkg::CFG_XRES, 48'd4096);
        write_reg(phc_pkg::CFG_YRES, 48'd4096);
        write_reg(phc_pkg::CFG_CENTER, {16'h1000, 16'h0000, 16'h0000});
        write_reg(phc_pkg::CFG_U_AXIS, {16'h0000, 16'h0000, 16'h1000});
        write_reg(phc_pkg::CFG_V_AXIS, {16'h0000, 16'h1000, 16'h0000});
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2047, 12'd2048);
        send_pixel(12'h555, 12'haaa);
        send_pixel(12'haaa, 12'h555);

        // small image with far-out pixels, axis-aligned unit vectors reach full scale
        drain();
        write_reg(phc_pkg::CFG_XRES, 48'd1);
        write_reg(phc_pkg::CFG_YRES, 48'd3);
        write_reg(phc_pkg::CFG_CENTER, 48'h0000_0000_0001);
        write_reg(phc_pkg::CFG_U_AXIS, 48'h0000_0000_0000);
        write_reg(phc_pkg::CFG_V_AXIS, 48'h0000_0000_0000);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd2);
        drain();
        write_reg(phc_pkg::CFG_CENTER, 48'h0000_0000_ffff);
        send_pixel(12'd1, 12'd1);

        // random cameras
        for (int p = 0; p < 8; p++) begin
            random_camera();
            random_pixels(115);
        end

        // long receiver hold so the pipeline fills and stalls the input
        random_camera();
        rx_hold_req = 1'b1;
        tx_idle_en = 1'b0;
        random_pixels(120);
        tx_idle_en = 1'b1;
        // sender pause until everything is back
        drain();
        random_pixels(60);

        // closing stretch at full rate on both sides
        random_camera();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        random_pixels(120);
        random_camera();
        random_pixels(110);

        drain();
        $display("covered %0d pixels over %0d camera set-ups, %0d directions checked",
                 pixels_sent, phases + 4, sb.checked);
        $display("including zero resolution, off-image pixels and a long output stall");
        if (sb.errors == 0 && sb.dir_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

`default_nettype wire
